@@ rtl/vertex_project_to_viewport_defines.svh @@
// assertion macros for the vertex projection block
// used by the port checker; needs clk and rst in scope
`ifndef VERTEX_PROJECT_TO_VIEWPORT_DEFINES_SVH
`define VERTEX_PROJECT_TO_VIEWPORT_DEFINES_SVH

// same-cycle implication
`define VPV_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VPV_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/vpv_pkg.sv @@
// shared types and constants for the vertex projection block
// no dependencies
package vpv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W = 32;
  localparam int REG_W = 14;
  localparam int SCR_W = 31;
  localparam int ST_W = 2;
  localparam int IN_W = 136;
  localparam int OUT_W = 64;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  localparam logic [1:0] CFG_LEFT = 2'd0;
  localparam logic [1:0] CFG_TOP = 2'd1;
  localparam logic [1:0] CFG_WIDTH = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

  localparam logic [ST_W-1:0] ST_VISIBLE = 2'd0;
  localparam logic [ST_W-1:0] ST_DEPTH = 2'd1;
  localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd2;
  localparam logic [ST_W-1:0] ST_WZERO = 2'd3;

  typedef struct packed {
    logic en;
    logic first;
    logic last;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/vpv_mac.sv @@
// shared multiply-accumulate unit: registered 32x32 product, floor shift, accumulate
// depends on vpv_pkg
module vpv_mac import vpv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int CW = 67 - FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctrl_t               ctrl,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  output logic signed [CW-1:0]    acc,
  output logic                    row_done
);

  logic signed [2*VAL_W-1:0] prod;
  logic signed [2*VAL_W-1:0] prod_sh;
  logic vld_d, first_d, last_d;

  assign prod_sh = prod >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= 1'b0;
      row_done <= 1'b0;
    end else begin
      vld_d <= ctrl.en;
      row_done <= vld_d & last_d;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    first_d <= ctrl.first;
    last_d <= ctrl.last;
    if (vld_d) begin
      acc <= (first_d ? CW'(0) : acc) + CW'(prod_sh);
    end
  end

endmodule

@@ rtl/vpv_div.sv @@
// bit-serial scaled ratio: origin + floor((c+w) * size / (2w)), saturated
// depends on vpv_pkg
module vpv_div import vpv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int CW = 67 - FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [CW-1:0] c,
  input  logic signed [CW-1:0] w,
  input  logic [REG_W-1:0]     origin,
  input  logic [REG_W-1:0]     size,
  output div_stat_t            stat,
  output logic [SCR_W-1:0]     result
);

  localparam int KW = REG_W + FRAC_BITS;
  localparam int RW = CW + 2;
  localparam int TW = (KW + 1 > 32) ? KW + 1 : 32;
  localparam int CNTW = $clog2(KW);

  logic signed [CW:0] num_s, den_s;
  logic [CW:0] num, den;
  logic [RW-1:0] rem, t, den1, den2;
  logic [KW-1:0] k, q;
  logic [REG_W-1:0] org;
  logic [CNTW-1:0] cnt;
  logic [KW-1:0] q_next;
  logic [RW-1:0] rem_next;
  logic [TW-1:0] total;

  assign num_s = (CW+1)'(c) + (CW+1)'(w);
  assign den_s = (CW+1)'(w) <<< 1;
  assign den1 = RW'(den);
  assign den2 = RW'(den) << 1;
  assign t = (rem << 1) + (k[KW-1] ? RW'(num) : RW'(0));

  always_comb begin
    if (t >= den2) begin
      rem_next = t - den2;
      q_next = (q << 1) + KW'(2);
    end else if (t >= den1) begin
      rem_next = t - den1;
      q_next = (q << 1) + KW'(1);
    end else begin
      rem_next = t;
      q_next = q << 1;
    end
  end

  assign total = TW'({org, {FRAC_BITS{1'b0}}}) + TW'(q_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= !start && stat.busy && cnt == '0;
      if (start) begin
        stat.busy <= 1'b1;
      end else if (stat.busy && cnt == '0) begin
        stat.busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= w[CW-1] ? unsigned'(-num_s) : unsigned'(num_s);
      den <= w[CW-1] ? unsigned'(-den_s) : unsigned'(den_s);
      k <= {size, {FRAC_BITS{1'b0}}};
      org <= origin;
      rem <= '0;
      q <= '0;
      cnt <= CNTW'(KW - 1);
    end else if (stat.busy) begin
      rem <= rem_next;
      q <= q_next;
      k <= k << 1;
      cnt <= cnt - CNTW'(1);
      if (cnt == '0) begin
        result <= (total > TW'({SCR_W{1'b1}})) ? {SCR_W{1'b1}} : SCR_W'(total);
      end
    end
  end

endmodule

@@ rtl/vertex_project_to_viewport.sv @@
// channel   dir  width  contents
// s_*       in   136+1  load word (coefficient) or vertex word, kind in tuser
// m_*       out  64     one projected vertex per vertex word
// cfg_*     in   2+14   viewport rectangle registers
//
// a load word is taken in the accept step alone; a vertex passes the accept step, the
// shared multiplier for every matrix product, its drain, the test step, the bit-serial
// divider for x and then for y, and the output step, with Q16.16 values by default;
// a rejected vertex skips the divider
// rst (synchronous) restores the identity matrix and a zero rectangle
// a vertex waits in its last step while the output word is not taken
// depends on vpv_pkg, vpv_mac, vpv_div
module vertex_project_to_viewport import vpv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,  // coef_slot, coef_value, pos_x, pos_y, pos_z, zero pad
  input  logic              s_tuser,  // op
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,  // screen_x, screen_y, status
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [REG_W-1:0]  cfg_data
);

  localparam int CW = 67 - FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DIVX = 3'd4;
  localparam logic [2:0] S_DIVY = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;
  logic [VAL_W-1:0] coef [16];
  logic [REG_W-1:0] view_left, view_top, view_width, view_height;
  logic signed [VAL_W-1:0] vx, vy, vz, vin;
  logic [3:0] cnt;
  logic [1:0] rows;
  logic signed [CW-1:0] clip [4];
  logic [ST_W-1:0] st;
  logic [ST_W-1:0] res_st;
  logic [SCR_W-1:0] sx, sy;

  mac_ctrl_t mctl;
  logic signed [CW-1:0] acc;
  logic row_done;
  logic div_start;
  div_stat_t dstat;
  logic [SCR_W-1:0] dres;
  logic signed [CW-1:0] div_c;
  logic [REG_W-1:0] div_org, div_size;
  logic [CW-1:0] ax, ay, az, aw;
  logic take;
  logic out_load;

  assign s_tready = (state == S_IDLE);
  assign take = s_tvalid && s_tready;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    unique case (cnt[1:0])
      2'd0: vin = vx;
      2'd1: vin = vy;
      2'd2: vin = vz;
      default: vin = VAL_W'(1) << FRAC_BITS;
    endcase
  end

  assign mctl.en = (state == S_MUL);
  assign mctl.first = (cnt[1:0] == 2'd0);
  assign mctl.last = (cnt[1:0] == 2'd3);

  vpv_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .rst(rst), .ctrl(mctl), .a(coef[cnt]), .b(vin),
    .acc(acc), .row_done(row_done)
  );

  assign ax = clip[0][CW-1] ? unsigned'(-clip[0]) : unsigned'(clip[0]);
  assign ay = clip[1][CW-1] ? unsigned'(-clip[1]) : unsigned'(clip[1]);
  assign az = clip[2][CW-1] ? unsigned'(-clip[2]) : unsigned'(clip[2]);
  assign aw = clip[3][CW-1] ? unsigned'(-clip[3]) : unsigned'(clip[3]);

  assign div_c = (state == S_CHECK) ? clip[0] : clip[1];
  assign div_org = (state == S_CHECK) ? view_left : view_top;
  assign div_size = (state == S_CHECK) ? view_width : view_height;
  assign div_start = (state == S_CHECK && st == ST_VISIBLE) ||
                     (state == S_DIVX && dstat.done);

  always_comb begin
    priority if (clip[3] == '0) begin
      st = ST_WZERO;
    end else if (az > aw) begin
      st = ST_DEPTH;
    end else if ((view_width != '0 && ax > aw) || (view_height != '0 && ay > aw)) begin
      st = ST_OUTSIDE;
    end else begin
      st = ST_VISIBLE;
    end
  end

  vpv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .c(div_c), .w(clip[3]),
    .origin(div_org), .size(div_size), .stat(dstat), .result(dres)
  );

  // matrix and viewport registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        coef[i] <= (i % 5 == 0) ? VAL_W'(1) << FRAC_BITS : '0;
      end
      view_left <= '0;
      view_top <= '0;
      view_width <= '0;
      view_height <= '0;
    end else begin
      if (take && s_tuser == OP_LOAD) begin
        coef[s_tdata[3:0]] <= s_tdata[35:4];
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_LEFT: view_left <= cfg_data;
          CFG_TOP: view_top <= cfg_data;
          CFG_WIDTH: view_width <= cfg_data;
          CFG_HEIGHT: view_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      cnt <= '0;
      rows <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take && s_tuser == OP_VERTEX) begin
            cnt <= '0;
            rows <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (row_done && rows == 2'd3) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (st == ST_VISIBLE) ? S_DIVX : S_DONE;
        end
        S_DIVX: begin
          if (dstat.done) begin
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (dstat.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (row_done) begin
        rows <= rows + 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (take && s_tuser == OP_VERTEX) begin
      vx <= s_tdata[67:36];
      vy <= s_tdata[99:68];
      vz <= s_tdata[131:100];
    end
    if (row_done) begin
      clip[0] <= clip[1];
      clip[1] <= clip[2];
      clip[2] <= clip[3];
      clip[3] <= acc;
    end
    if (state == S_CHECK) begin
      res_st <= st;
    end
    if (state == S_DIVX && dstat.done) begin
      sx <= dres;
    end
    if (state == S_DIVY && dstat.done) begin
      sy <= dres;
    end
    if (out_load) begin
      m_tdata <= (res_st == ST_VISIBLE) ? {ST_VISIBLE, sy, sx} :
                                          {res_st, {(2*SCR_W){1'b0}}};
    end
  end

endmodule

@@ rtl/vpv_checker.sv @@
// port-level checker for the vertex projection block, bound to the top level
// depends on vpv_pkg and vertex_project_to_viewport_defines.svh
`include "vertex_project_to_viewport_defines.svh"

module vpv_checker import vpv_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  `VPV_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
  `VPV_NEXT(a_vertex_busy, s_tvalid && s_tready && s_tuser == OP_VERTEX, !s_tready, "ready right after a vertex")
  `VPV_NEXT(a_load_quiet, s_tvalid && s_tready && s_tuser == OP_LOAD, !$rose(m_tvalid), "result after a load word")
  `VPV_IMPLIES(a_reject_zero, m_tvalid && m_tdata[63:62] != ST_VISIBLE, m_tdata[61:0] == '0, "rejected vertex has a position")

endmodule

bind vertex_project_to_viewport vpv_checker u_vpv_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
